[rtl/assert_macros.svh]
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/slnt_pkg.sv]
package slnt_pkg;

    localparam int SLNT_CAPACITY = 256;

    // width used for slot against count or cell index compares
    localparam int SLOT_CMP_W = 16;

    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_CMP  = 2'd1;
    localparam logic [1:0] CELL_INS  = 2'd2;
    localparam logic [1:0] CELL_DEL  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] search_key;
        logic [7:0]         slot;
        logic [31:0]        record_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] found_slot;
        logic [8:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic signed [63:0] key;
        logic [31:0]        rid;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] key;
        logic [31:0]        rid;
        logic [7:0]         slot;
    } cell_cmd_t;

endpackage

[rtl/slnt_cell.sv]
module slnt_cell
    import slnt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  entry_t    left,
    input  entry_t    right,
    output entry_t    entry,
    output logic      less
);

    localparam logic [SLOT_CMP_W-1:0] IDX_W = SLOT_CMP_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   less_reg;
    logic   less_next;
    logic [SLOT_CMP_W-1:0] slot_w;

    assign slot_w = SLOT_CMP_W'(cmd.slot);

    always_comb
    begin
        entry_next = entry_reg;
        less_next  = less_reg;
        case (cmd.op)
            CELL_CMP:
            begin
                less_next = ($signed(entry_reg.key) < $signed(cmd.key));
            end
            CELL_INS:
            begin
                if (IDX_W == slot_w)
                begin
                    entry_next.key = cmd.key;
                    entry_next.rid = cmd.rid;
                end
                else if (IDX_W > slot_w)
                begin
                    entry_next = left;
                end
            end
            CELL_DEL:
            begin
                if (IDX_W >= slot_w)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        less_reg  <= less_next;
    end

    assign entry = entry_reg;
    assign less  = less_reg;

endmodule

[rtl/slnt_search.sv]
`include "assert_macros.svh"

module slnt_search
    import slnt_pkg::*;
#(
    parameter int CAPACITY = SLNT_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int IW = $clog2(CAPACITY)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CW-1:0]       count,
    input  logic [CAPACITY-1:0] less,
    output logic                done,
    output logic [CW-1:0]       pos
);

    logic          busy_reg;
    logic          busy_next;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] lo_next;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] hi_next;
    logic [CW-1:0] mid;
    logic          open;

    assign open = (lo_reg < hi_reg);
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        busy_next = busy_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        if (start)
        begin
            busy_next = 1'b1;
            lo_next   = '0;
            hi_next   = count;
        end
        else if (busy_reg)
        begin
            if (open)
            begin
                // one halving step per cycle
                if (less[mid[IW-1:0]])
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lo_reg   <= '0;
            hi_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    assign done = busy_reg && !open;
    assign pos  = lo_reg;

    `ASSERT_IMPLY(a_lo_le_hi, clk, rst_n, busy_reg, lo_reg <= hi_reg, "search bounds crossed")

endmodule

[rtl/sorted_leaf_node_table_top.sv]
// sorted leaf node table: one leaf node of signed 64-bit keys, each with a
// 32-bit record id, held in a chain of cells, plus an entry count
// request channel (req_valid / req_stall / req) takes one item: find lower
// bound, insert at slot, or remove at slot; an item is taken when req_valid
// is high and req_stall is low
// response channel (rsp_valid / rsp_stall / rsp) returns one item per request
// with status, found slot and the entry count after the operation
// insert writes the new entry at the slot while the cells above it shift from
// their left neighbor; remove shifts the cells from the slot up from the right;
// find: all cells compare against the key at once, then a halving search
// walks the registered compare bits one step a cycle, for at most
// clog2(CAPACITY+1) steps; every item passes the execute and finish states, and
// a new item is taken only once the last response is in the output register
// the output register lets the next item be accepted while a response waits;
// a finished item holds in its last state while rsp_stall keeps the register full
// reset clears the count and the control state; cell contents stay undefined
// and are only read below the count
`include "assert_macros.svh"

module sorted_leaf_node_table_top
    import slnt_pkg::*;
#(
    parameter int CAPACITY = SLNT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    in_item_t      cmd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [CW-1:0] found_reg;
    logic [CW-1:0] found_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_reg;

    logic          accept;
    logic          out_load;
    logic          search_start;
    logic          search_done;
    logic [CW-1:0] search_pos;
    cell_cmd_t     cell_cmd;
    logic [1:0]    exec_status;
    logic [SLOT_CMP_W-1:0] slot_w;
    logic [SLOT_CMP_W-1:0] count_w;

    entry_t              entries [CAPACITY];
    logic [CAPACITY-1:0] less_vec;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || !rsp_stall);

    assign slot_w  = SLOT_CMP_W'(cmd_reg.slot);
    assign count_w = SLOT_CMP_W'(count_reg);

    // bounds checks, full check ahead of the position check
    always_comb
    begin
        exec_status = ST_OK;
        case (cmd_reg.kind)
            KIND_INSERT:
            begin
                if (count_reg >= CW'(CAPACITY))
                begin
                    exec_status = ST_FULL;
                end
                else if (slot_w > count_w)
                begin
                    exec_status = ST_RANGE;
                end
            end
            KIND_REMOVE:
            begin
                if (slot_w >= count_w)
                begin
                    exec_status = ST_RANGE;
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // command seen by every cell, active only during the execute cycle
    always_comb
    begin
        cell_cmd.op   = CELL_HOLD;
        cell_cmd.key  = cmd_reg.search_key;
        cell_cmd.rid  = cmd_reg.record_id;
        cell_cmd.slot = cmd_reg.slot;
        if (state_reg == S_EXEC)
        begin
            case (cmd_reg.kind)
                KIND_FIND:   cell_cmd.op = CELL_CMP;
                KIND_INSERT: cell_cmd.op = (exec_status == ST_OK) ? CELL_INS : CELL_HOLD;
                KIND_REMOVE: cell_cmd.op = (exec_status == ST_OK) ? CELL_DEL : CELL_HOLD;
                default:     cell_cmd.op = CELL_HOLD;
            endcase
        end
    end

    // search start comes with the compare; its steps read the registered compare bits
    assign search_start = (state_reg == S_EXEC) && (cmd_reg.kind == KIND_FIND);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = exec_status;
                found_next  = '0;
                if (cmd_reg.kind == KIND_FIND)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_FINISH;
                    if (exec_status == ST_OK)
                    begin
                        if (cmd_reg.kind == KIND_INSERT)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        else if (cmd_reg.kind == KIND_REMOVE)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (search_done)
                begin
                    found_next = search_pos;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req;
        end
        status_reg <= status_next;
        found_reg  <= found_next;
        if (out_load)
        begin
            out_reg.status      <= status_reg;
            out_reg.found_slot  <= 9'(found_reg);
            out_reg.entry_count <= 9'(count_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // chain of cells, each wired to its neighbors; the end cells see zero past the ends
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_in;
        entry_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = entries[i+1];
        end

        slnt_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cell_cmd),
            .left  (left_in),
            .right (right_in),
            .entry (entries[i]),
            .less  (less_vec[i])
        );
    end

    slnt_search #(
        .CAPACITY (CAPACITY)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (search_start),
        .count (count_reg),
        .less  (less_vec),
        .done  (search_done),
        .pos   (search_pos)
    );

    `ASSERT_IMPLY(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count over cap")
    `ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != S_EXEC, $stable(count_reg), "count moved")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb
    import slnt_pkg::*;
();

    localparam int CAP = SLNT_CAPACITY;

    // kind code that the block leaves unused
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic signed [63:0] KEY_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] KEY_MAX = {1'b0, {63{1'b1}}};

    localparam int PHASE_ITEMS = 545;   // random items per phase
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STUCK_LIMIT = 4000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 24;    // tail after the drain, longer than the longest find

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block ports; the inputs driven here are known from time zero
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_item_t  req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_item_t rsp;

    sorted_leaf_node_table_top #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // leaf node mirror: keys, record ids and the entry count
    // ------------------------------------------------------------------
    logic signed [63:0] node_keys [CAP];
    logic [31:0]        node_rids [CAP];
    int unsigned        node_count = 0;

    // first position whose key is not less than the probe, by halving steps;
    // on an unsorted node the answer simply follows wherever the steps lead
    function automatic int unsigned lower_bound_of(input logic signed [63:0] probe);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = node_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (node_keys[mid] < probe)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // apply one item to the mirror and return the response it should give
    function automatic out_item_t apply_to_node(input in_item_t it);
        out_item_t   res;
        int unsigned pos;
        int unsigned i;
        res = '0;
        pos = 32'(it.slot);
        case (it.kind)
            KIND_FIND:
            begin
                res.found_slot = 9'(lower_bound_of(it.search_key));
            end
            KIND_INSERT:
            begin
                // full check wins over the position check
                if (node_count >= CAP)
                    res.status = ST_FULL;
                else if (pos > node_count)
                    res.status = ST_RANGE;
                else
                begin
                    for (i = node_count; i > pos; i--)
                    begin
                        node_keys[i] = node_keys[i - 1];
                        node_rids[i] = node_rids[i - 1];
                    end
                    node_keys[pos] = it.search_key;
                    node_rids[pos] = it.record_id;
                    node_count++;
                end
            end
            KIND_REMOVE:
            begin
                // also covers remove on an empty node
                if (pos >= node_count)
                    res.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < node_count; i++)
                    begin
                        node_keys[i] = node_keys[i + 1];
                        node_rids[i] = node_rids[i + 1];
                    end
                    node_count--;
                end
            end
            default: ;  // spare kind: no change, plain ok
        endcase
        res.entry_count = 9'(node_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------
    out_item_t   pending_rsp[$];    // responses owed by the block, oldest first
    out_item_t   rsp_want;
    int          failures = 0;
    int          items_sent = 0;
    int          rsp_checked = 0;
    int          status_tally[4] = '{0, 0, 0, 0};
    int          finds_sent = 0;
    int unsigned peak_count = 0;
    int          snd_idle_pct = 11;
    int          rcv_idle_pct = 60;
    bit          hold_off_req = 1'b0;
    bit          growing = 1'b1;
    int          stuck_cycles = 0;

    // ------------------------------------------------------------------
    // response side: random stall, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                // keep the output full so that the input backs up
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // response checker: every taken response against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response item with none owed: status %0d found_slot %0d entry_count %0d",
                       rsp.status, rsp.found_slot, rsp.entry_count);
                failures++;
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                rsp_checked++;
                if (rsp.status !== rsp_want.status)
                begin
                    $error("status: expected %0d, got %0d", rsp_want.status, rsp.status);
                    failures++;
                end
                if (rsp.found_slot !== rsp_want.found_slot)
                begin
                    $error("found_slot: expected %0d, got %0d",
                           rsp_want.found_slot, rsp.found_slot);
                    failures++;
                end
                if (rsp.entry_count !== rsp_want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           rsp_want.entry_count, rsp.entry_count);
                    failures++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d responses still owed",
                 STUCK_LIMIT, pending_rsp.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one item, hold it until taken, then log what it should answer;
    // a fixed answer from the table replaces the mirror's where one is given
    task automatic send_item(input in_item_t it, input bit fixed, input out_item_t fixed_rsp);
        out_item_t owed;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle_pct);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        owed = apply_to_node(it);
        if (fixed)
            owed = fixed_rsp;
        pending_rsp.push_back(owed);
        items_sent++;
        status_tally[owed.status]++;
        if (it.kind == KIND_FIND)
            finds_sent++;
        if (node_count > peak_count)
            peak_count = node_count;
    endtask

    // keys: extremes, a narrow band around zero for duplicates, keys already
    // stored, and full-width random values
    function automatic logic signed [63:0] pick_key();
        logic signed [63:0] k;
        case ($urandom_range(0, 9))
            0: k = KEY_MIN;
            1: k = KEY_MAX;
            2, 3:
            begin
                k = 64'($urandom_range(0, 16));
                k = k - 64'sd8;
            end
            4, 5:
            begin
                if (node_count > 0)
                    k = node_keys[$urandom_range(0, node_count - 1)];
                else
                    k = {$urandom(), $urandom()};
            end
            default: k = {$urandom(), $urandom()};
        endcase
        return k;
    endfunction

    // mostly well-formed traffic: sorted inserts while the node grows,
    // in-range removes while it drains, finds throughout, plus some noise
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned roll;
        it.kind       = KIND_FIND;
        it.search_key = pick_key();
        it.slot       = 8'($urandom_range(0, 255));
        it.record_id  = $urandom();
        // linger a few items at full so that rejected inserts show up
        if (node_count >= CAP && $urandom_range(0, 5) == 0)
            growing = 1'b0;
        if (node_count == 0)
            growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            // noise: any kind, any slot, may break the ordering
            it.kind = 2'($urandom_range(0, 3));
        end
        else if (roll < (growing ? 73 : 15))
        begin
            it.kind = KIND_INSERT;
            it.slot = 8'(lower_bound_of(it.search_key));
        end
        else if (roll < (growing ? 80 : 75))
        begin
            it.kind = KIND_REMOVE;
            if (node_count > 0)
                it.slot = 8'($urandom_range(0, node_count - 1));
        end
        return it;
    endfunction

    // directed table
    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t answer;
    } table_row_t;

    table_row_t directed_rows[$];

    task automatic add_row(input logic [1:0] kind, input logic signed [63:0] key,
                           input logic [7:0] slot, input logic [31:0] rid,
                           input bit fixed, input logic [1:0] st,
                           input logic [8:0] found, input logic [8:0] count);
        table_row_t row;
        row.item.kind              = kind;
        row.item.search_key        = key;
        row.item.slot              = slot;
        row.item.record_id         = rid;
        row.fixed                  = fixed;
        row.answer.status          = st;
        row.answer.found_slot      = found;
        row.answer.entry_count     = count;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;

        // empty node: find gives zero; remove at 0 and insert past 0 are out of range
        add_row(KIND_FIND,   64'sd0,   8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd0);
        add_row(KIND_REMOVE, 64'sd0,   8'd0,   32'd0,        1, ST_RANGE, 9'd0, 9'd0);
        add_row(KIND_INSERT, 64'sd5,   8'd1,   32'd1,        1, ST_RANGE, 9'd0, 9'd0);
        add_row(KIND_INSERT, KEY_MAX,  8'd255, 32'hFFFF_FFFF, 1, ST_RANGE, 9'd0, 9'd0);
        // spare kind with every field bit set
        add_row(KIND_SPARE,  -64'sd1,  8'd255, 32'hFFFF_FFFF, 1, ST_OK,    9'd0, 9'd0);
        // build MIN, -1, 0, MAX with extreme record ids
        add_row(KIND_INSERT, KEY_MIN,  8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd1);
        add_row(KIND_INSERT, KEY_MAX,  8'd1,   32'hFFFF_FFFF, 1, ST_OK,    9'd0, 9'd2);
        add_row(KIND_INSERT, 64'sd0,   8'd1,   32'h5555_5555, 1, ST_OK,    9'd0, 9'd3);
        add_row(KIND_INSERT, -64'sd1,  8'd1,   32'hAAAA_AAAA, 1, ST_OK,    9'd0, 9'd4);
        add_row(KIND_FIND,   KEY_MIN,  8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd4);
        add_row(KIND_FIND,   KEY_MAX,  8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        add_row(KIND_FIND,   KEY_MIN + 64'sd1, 8'd0, 32'd0,  0, ST_OK,    9'd0, 9'd0);
        add_row(KIND_FIND,   64'sd1,   8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        add_row(KIND_FIND,   -64'sd2,  8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        // append at the count, duplicate of the top key
        add_row(KIND_INSERT, KEY_MAX,  8'd4,   32'd1,        1, ST_OK,    9'd0, 9'd5);
        add_row(KIND_FIND,   KEY_MAX,  8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        add_row(KIND_SPARE,  64'sd0,   8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd5);
        // remove at the count is out of range; first and last are fine
        add_row(KIND_REMOVE, 64'sd0,   8'd5,   32'd0,        1, ST_RANGE, 9'd0, 9'd5);
        add_row(KIND_REMOVE, 64'sd0,   8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd4);
        add_row(KIND_REMOVE, 64'sd0,   8'd3,   32'd0,        1, ST_OK,    9'd0, 9'd3);
        add_row(KIND_INSERT, 64'sd7,   8'd5,   32'd7,        1, ST_RANGE, 9'd0, 9'd3);
        add_row(KIND_FIND,   64'sd0,   8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        // out-of-order insert: find follows the halving steps regardless
        add_row(KIND_INSERT, KEY_MAX,  8'd0,   32'd9,        1, ST_OK,    9'd0, 9'd4);
        add_row(KIND_FIND,   64'sd0,   8'd0,   32'd0,        0, ST_OK,    9'd0, 9'd0);
        add_row(KIND_REMOVE, 64'sd0,   8'd0,   32'd0,        1, ST_OK,    9'd0, 9'd3);

        // reset once at the start
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].answer);

        // random part: sender idles lightly / receiver heavily, then swapped,
        // then both flat out with one long output hold-off partway through
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 11;
                    rcv_idle_pct = 60;
                end
                1:
                begin
                    snd_idle_pct = 60;
                    rcv_idle_pct = 11;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == 150)
                    hold_off_req = 1'b1;
                send_item(random_item(), 1'b0, '0);
            end
        end
        req_valid <= 1'b0;

        // drain, then give a late extra response a chance to show up
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items (%0d finds), %0d responses checked, peak entry count %0d",
                 items_sent, finds_sent, rsp_checked, peak_count);
        $display("statuses seen: ok %0d, node full %0d, out of range %0d",
                 status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_RANGE]);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/slnt_pkg.sv
rtl/slnt_cell.sv
rtl/slnt_search.sv
rtl/sorted_leaf_node_table_top.sv
bench/tb.sv
